[rtl/aheg_pkg.sv]
// ----------------------------------------------------------------------------
// aheg_pkg
// Shared types, constants and register indexes of the hold-style envelope.
// ----------------------------------------------------------------------------
package aheg_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int HOLD_BITS_DEF = 24;
	localparam int LEVEL_W       = 17;
	localparam int FACTOR_W      = 16;
	localparam int FRAC_BITS     = 16;
	localparam int HOLD_CFG_W    = 24;
	localparam int CFG_DATA_W    = 24;
	localparam int CFG_IDX_W     = 3;
	localparam int STAGE_W       = 3;

	localparam logic [LEVEL_W-1:0] ONE_Q16 = LEVEL_W'(2 ** FRAC_BITS);

	localparam logic [CFG_IDX_W-1:0] REG_MODE    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_DECAY   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_HOLD    = CFG_IDX_W'(5);

	localparam logic                  MODE_RST    = 1'b1;
	localparam logic [FACTOR_W-1:0]   ATTACK_RST  = FACTOR_W'(655);
	localparam logic [FACTOR_W-1:0]   DECAY_RST   = FACTOR_W'(65000);
	localparam logic [LEVEL_W-1:0]    SUSTAIN_RST = LEVEL_W'(32768);
	localparam logic [FACTOR_W-1:0]   RELEASE_RST = FACTOR_W'(65000);
	localparam logic [HOLD_CFG_W-1:0] HOLD_RST    = '0;

	localparam logic [STAGE_W-1:0] STAGE_IDLE    = STAGE_W'(0);
	localparam logic [STAGE_W-1:0] STAGE_ATTACK  = STAGE_W'(1);
	localparam logic [STAGE_W-1:0] STAGE_DECAY   = STAGE_W'(2);
	localparam logic [STAGE_W-1:0] STAGE_HOLD    = STAGE_W'(3);
	localparam logic [STAGE_W-1:0] STAGE_RELEASE = STAGE_W'(4);

	typedef enum logic [1:0] {
		WR_NONE,
		WR_SCALE,
		WR_RAW
	} wr_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEC_MUL,
		ST_DEC_APPLY,
		ST_REL_MUL,
		ST_REL_APPLY,
		ST_SCL_MUL,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic                          gate;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic [LEVEL_W-1:0]            level;
		logic [STAGE_W-1:0]            stage;
	} out_item_t;

	typedef struct packed {
		logic                  mode_adsr;
		logic [FACTOR_W-1:0]   attack_step;
		logic [FACTOR_W-1:0]   decay_factor;
		logic [LEVEL_W-1:0]    sustain_level;
		logic [FACTOR_W-1:0]   release_factor;
		logic [HOLD_CFG_W-1:0] hold_samples;
	} cfg_t;

	typedef struct packed {
		logic load_in;
		logic mul_decay;
		logic eval_hold;
		logic mul_release;
		logic apply_release;
		logic mul_scale;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_stat_t;

endpackage

[rtl/aheg_cfg.sv]
// ----------------------------------------------------------------------------
// aheg_cfg
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module aheg_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             we,
	input  logic [aheg_pkg::CFG_IDX_W-1:0]   idx,
	input  logic [aheg_pkg::CFG_DATA_W-1:0]  wdata,
	output aheg_pkg::cfg_t                   cfg
);
	import aheg_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_adsr      <= MODE_RST;
			cfg_q.attack_step    <= ATTACK_RST;
			cfg_q.decay_factor   <= DECAY_RST;
			cfg_q.sustain_level  <= SUSTAIN_RST;
			cfg_q.release_factor <= RELEASE_RST;
			cfg_q.hold_samples   <= HOLD_RST;
		end else if (we) begin
			case (idx)
				REG_MODE:    cfg_q.mode_adsr      <= wdata[0];
				REG_ATTACK:  cfg_q.attack_step    <= wdata[FACTOR_W-1:0];
				REG_DECAY:   cfg_q.decay_factor   <= wdata[FACTOR_W-1:0];
				REG_SUSTAIN: cfg_q.sustain_level  <= wdata[LEVEL_W-1:0];
				REG_RELEASE: cfg_q.release_factor <= wdata[FACTOR_W-1:0];
				REG_HOLD:    cfg_q.hold_samples   <= wdata[HOLD_CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/aheg_ctrl.sv]
// ----------------------------------------------------------------------------
// aheg_ctrl
// Sequencer that steps one sample through the envelope datapath.
// ----------------------------------------------------------------------------
module aheg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  aheg_pkg::dp_stat_t  stat,
	output aheg_pkg::dp_cmd_t   cmd
);
	import aheg_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DEC_MUL;
				end
			end
			ST_DEC_MUL:   state_d = ST_DEC_APPLY;
			ST_DEC_APPLY: state_d = ST_REL_MUL;
			ST_REL_MUL:   state_d = ST_REL_APPLY;
			ST_REL_APPLY: state_d = ST_SCL_MUL;
			ST_SCL_MUL:   state_d = ST_OUT;
			ST_OUT: begin
				if (!stat.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_DEC_MUL:   cmd.mul_decay     = 1'b1;
			ST_DEC_APPLY: cmd.eval_hold     = 1'b1;
			ST_REL_MUL:   cmd.mul_release   = 1'b1;
			ST_REL_APPLY: cmd.apply_release = 1'b1;
			ST_SCL_MUL:   cmd.mul_scale     = 1'b1;
			ST_OUT:       cmd.load_out      = !stat.out_busy;
			default: begin
			end
		endcase
	end

endmodule

[rtl/aheg_dp.sv]
// ----------------------------------------------------------------------------
// aheg_dp
// Envelope state, shared multiplier, sample scaling and output register.
// ----------------------------------------------------------------------------
module aheg_dp #(
	parameter int HOLD_BITS = aheg_pkg::HOLD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aheg_pkg::dp_cmd_t    cmd,
	output aheg_pkg::dp_stat_t   stat,
	input  aheg_pkg::cfg_t       cfg,
	input  aheg_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output aheg_pkg::out_item_t  out_data
);
	import aheg_pkg::*;

	localparam int MUL_A_W = ((SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W) + 1;
	localparam int MUL_B_W = LEVEL_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int SUM_W   = LEVEL_W + 1;
	localparam logic signed [PROD_W-1:0] SCL_HI = PROD_W'(2 ** (SAMPLE_BITS - 1) - 1);
	localparam logic signed [PROD_W-1:0] SCL_LO = PROD_W'(-(2 ** (SAMPLE_BITS - 1)));

	logic [LEVEL_W-1:0]            level_q;
	logic                          attack_q;
	logic                          decay_q;
	logic                          hold_q;
	logic                          release_q;
	logic [HOLD_BITS-1:0]          hold_cnt_q;
	logic signed [SAMPLE_BITS-1:0] last_out_q;
	wr_kind_t                      wr_q;
	logic                          out_valid_q;

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          gate_q;
	logic signed [PROD_W-1:0]      prod_q;
	out_item_t                     out_q;

	logic                          adsr;
	logic [HOLD_BITS-1:0]          hold_tgt;

	logic signed [MUL_A_W-1:0]     mul_a;
	logic signed [MUL_B_W-1:0]     mul_b;
	logic signed [PROD_W-1:0]      mul_p;
	logic [LEVEL_W-1:0]            mulq_res;
	logic signed [PROD_W-1:0]      scl_shift;
	logic signed [SAMPLE_BITS-1:0] scl_res;

	logic                          start;
	logic [SUM_W-1:0]              lvl_sum;
	logic [LEVEL_W-1:0]            lvl1;
	logic                          a1;
	logic                          d1;
	logic                          h1;
	logic                          r1;
	logic [HOLD_BITS-1:0]          hc1;
	wr_kind_t                      wr1;

	logic [LEVEL_W-1:0]            lvl4;
	logic                          d4;
	logic                          h4;
	logic                          r4;
	logic [HOLD_BITS-1:0]          hc4;
	wr_kind_t                      wr4;
	wr_kind_t                      wr_hold;

	logic signed [SAMPLE_BITS-1:0] new_last;
	logic [STAGE_W-1:0]            stage_code;

	assign adsr     = cfg.mode_adsr;
	assign hold_tgt = HOLD_BITS'(cfg.hold_samples);
	assign wr_hold  = adsr ? WR_SCALE : WR_RAW;

	always_comb begin
		mul_a = MUL_A_W'(level_q);
		mul_b = MUL_B_W'(cfg.decay_factor);
		if (cmd.mul_scale) begin
			mul_a = MUL_A_W'(sample_q);
			mul_b = MUL_B_W'(level_q);
		end else if (cmd.mul_release) begin
			mul_b = MUL_B_W'(cfg.release_factor);
		end
	end

	assign mul_p    = mul_a * mul_b;
	assign mulq_res = prod_q[FRAC_BITS +: LEVEL_W];

	always_comb begin
		scl_shift = prod_q >>> FRAC_BITS;
		if (scl_shift > SCL_HI) begin
			scl_res = SCL_HI[SAMPLE_BITS-1:0];
		end else if (scl_shift < SCL_LO) begin
			scl_res = SCL_LO[SAMPLE_BITS-1:0];
		end else begin
			scl_res = scl_shift[SAMPLE_BITS-1:0];
		end
	end

	// A new note starts only when no attack, hold or (in ADSR form) decay is running.
	always_comb begin
		start   = in_data.gate && !attack_q && !hold_q && (!adsr || !decay_q);
		a1      = attack_q || start;
		d1      = decay_q && !(start && adsr);
		h1      = hold_q;
		r1      = release_q && !start;
		hc1     = start ? '0 : hold_cnt_q;
		lvl_sum = SUM_W'(level_q) + SUM_W'(cfg.attack_step);
		lvl1    = level_q;
		wr1     = WR_NONE;
		if (a1) begin
			lvl1 = (lvl_sum > SUM_W'(ONE_Q16)) ? ONE_Q16 : lvl_sum[LEVEL_W-1:0];
			wr1  = WR_SCALE;
		end
		if (lvl1 >= ONE_Q16) begin
			lvl1 = ONE_Q16;
			a1   = 1'b0;
			if (adsr) begin
				d1 = 1'b1;
			end else begin
				h1 = 1'b1;
			end
		end
	end

	always_comb begin
		lvl4 = level_q;
		d4   = decay_q;
		h4   = hold_q;
		r4   = release_q;
		hc4  = hold_cnt_q;
		wr4  = wr_q;
		if (adsr && decay_q) begin
			lvl4 = mulq_res;
			wr4  = WR_SCALE;
			if (mulq_res <= cfg.sustain_level) begin
				d4 = 1'b0;
				h4 = 1'b1;
			end
		end
		if ((hc4 < hold_tgt) && h4) begin
			wr4 = wr_hold;
			hc4 = hc4 + HOLD_BITS'(1);
		end
		if (hc4 == hold_tgt) begin
			if (gate_q) begin
				wr4 = wr_hold;
			end else begin
				h4 = 1'b0;
				r4 = 1'b1;
			end
		end
	end

	always_comb begin
		case (wr_q)
			WR_SCALE: new_last = scl_res;
			WR_RAW:   new_last = sample_q;
			default:  new_last = last_out_q;
		endcase
	end

	always_comb begin
		if (attack_q) begin
			stage_code = STAGE_ATTACK;
		end else if (decay_q) begin
			stage_code = STAGE_DECAY;
		end else if (hold_q) begin
			stage_code = STAGE_HOLD;
		end else if (release_q) begin
			stage_code = STAGE_RELEASE;
		end else begin
			stage_code = STAGE_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			attack_q    <= 1'b0;
			decay_q     <= 1'b0;
			hold_q      <= 1'b0;
			release_q   <= 1'b0;
			hold_cnt_q  <= '0;
			last_out_q  <= '0;
			wr_q        <= WR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				level_q    <= lvl1;
				attack_q   <= a1;
				decay_q    <= d1;
				hold_q     <= h1;
				release_q  <= r1;
				hold_cnt_q <= hc1;
				wr_q       <= wr1;
			end
			if (cmd.eval_hold) begin
				level_q    <= lvl4;
				decay_q    <= d4;
				hold_q     <= h4;
				release_q  <= r4;
				hold_cnt_q <= hc4;
				wr_q       <= wr4;
			end
			if (cmd.apply_release && release_q && (level_q != '0)) begin
				level_q <= mulq_res;
				wr_q    <= WR_SCALE;
			end
			if (cmd.load_out) begin
				last_out_q  <= new_last;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sample_q <= in_data.sample_in;
			gate_q   <= in_data.gate;
		end
		if (cmd.mul_decay || cmd.mul_release || cmd.mul_scale) begin
			prod_q <= mul_p;
		end
		if (cmd.load_out) begin
			out_q.sample_out <= new_last;
			out_q.level      <= level_q;
			out_q.stage      <= stage_code;
		end
	end

	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

endmodule

[rtl/adsr_hold_envelope_top.sv]
// ----------------------------------------------------------------------------
// adsr_hold_envelope_top
// in_ready is high only while the sequencer is idle, so a new sample is taken
// only once the last is loaded into the output register; three products pass
// in turn through the one shared multiplier (decay, release, sample scaling).
// Reset: arst_n clears the envelope state, the output valid flag and the
// sequencer at once and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module adsr_hold_envelope_top #(
	parameter int HOLD_BITS = aheg_pkg::HOLD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  aheg_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output aheg_pkg::out_item_t              out_data,
	input  logic                             cfg_we,
	input  logic [aheg_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [aheg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import aheg_pkg::*;

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	aheg_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_idx),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	aheg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	aheg_dp #(
		.HOLD_BITS (HOLD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg       (cfg),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[rtl/aheg_chk.sv]
// ----------------------------------------------------------------------------
// aheg_chk
// Port-level checks of the envelope block, bound to the top level.
// ----------------------------------------------------------------------------
module aheg_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input aheg_pkg::out_item_t              out_data
);
	import aheg_pkg::*;

	a_out_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Stalled result changed or dropped.");

	a_level_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.level <= ONE_Q16)
		else $error("Envelope level above unity.");

	a_attack_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.stage == STAGE_ATTACK) |-> out_data.level < ONE_Q16)
		else $error("Attack reported at full level.");

	a_idle_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.stage == STAGE_IDLE) |-> out_data.level == '0)
		else $error("Idle stage with nonzero level.");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("Result appeared one cycle after its transfer.");

endmodule

bind adsr_hold_envelope_top aheg_chk u_aheg_chk (.*);
